### hw/rtl/pfm_pkg.sv
package pfm_pkg;

  localparam int TimeW   = 32;
  localparam int CountW  = 24;
  localparam int ScaleW  = 32;
  localparam int VolW    = 56;
  localparam int TotalW  = 48;
  localparam int NumW    = 80;
  localparam int DenW    = 48;
  localparam int MulW    = 32;
  localparam int HalfVol = 28;
  localparam int StepW   = 7;
  localparam int DivSteps = NumW;

  localparam logic [21:0] LphFactor = 22'd3600000;

  localparam logic [31:0] MlPerPulseRst = 32'd65536;
  localparam logic [15:0] DebounceRst   = 16'd10;
  localparam logic [23:0] IdleWindowRst = 24'd1000000;
  localparam logic [15:0] CalibVolRst   = 16'd2000;
  localparam logic [31:0] EmptyDiffRst  = 32'd98304;
  localparam logic [31:0] EmptyMinRst   = 32'd1966080;

  localparam logic [2:0] RegMlPerPulse = 3'd0;
  localparam logic [2:0] RegDebounce   = 3'd1;
  localparam logic [2:0] RegIdleWindow = 3'd2;
  localparam logic [2:0] RegCalibVol   = 3'd3;
  localparam logic [2:0] RegEmptyDiff  = 3'd4;
  localparam logic [2:0] RegEmptyMin   = 3'd5;
  localparam logic [2:0] RegUnknown    = 3'd7;

  localparam logic [1:0] CalNone    = 2'd0;
  localparam logic [1:0] CalUpdated = 2'd1;
  localparam logic [1:0] CalNoFuel  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_MVOL, S_MLO, S_MHI, S_FSTART, S_FWAIT, S_TOTAL,
    S_CMUL, S_CSTART, S_CWAIT, S_FINISH
  } state_t;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [NumW-1:0] quo;
  } div_rsp_t;

endpackage

### hw/rtl/pfm_if.sv
interface pfm_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] time_us;
  logic        spraying;
  logic        armed;
  logic        calib_request;

  modport source (output valid, mode, time_us, spraying, armed, calib_request, input ready);
  modport sink   (input valid, mode, time_us, spraying, armed, calib_request, output ready);
endinterface

interface pfm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] flow_lph;
  logic [47:0] consumed_ml;
  logic [23:0] pulses_reported;
  logic        tank_empty;
  logic [31:0] scale_now;
  logic [1:0]  calib_status;

  modport source (output valid, flow_lph, consumed_ml, pulses_reported, tank_empty,
                  scale_now, calib_status, input ready);
  modport sink   (input valid, flow_lph, consumed_ml, pulses_reported, tank_empty,
                  scale_now, calib_status, output ready);
endinterface

### hw/rtl/pfm_div.sv
module pfm_div import pfm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [NumW-1:0]  num;
  logic [DenW-1:0]  den;
  logic [DenW-1:0]  rem;
  logic [StepW-1:0] cnt;
  logic             busy;
  logic             done;
  logic [DenW:0]    rem_sh;
  logic [DenW:0]    diff;

  assign rem_sh = {rem, num[NumW-1]};
  assign diff   = rem_sh - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        num  <= req.num;
        den  <= req.den;
      end else if (busy) begin
        // restore when the trial subtract goes negative
        if (!diff[DenW]) begin
          rem <= diff[DenW-1:0];
          num <= {num[NumW-2:0], 1'b1};
        end else begin
          rem <= rem_sh[DenW-1:0];
          num <= {num[NumW-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == StepW'(DivSteps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = num;

endmodule

### hw/rtl/pulse_flow_meter.sv
// Pulse flow meter with totalizer. Pulse edges (mode 0) are taken in idle: the
// first edge only sets the reference time, edges closer than debounce_us are
// dropped, and the rest add to the window pulse count and interval sum. A read
// tick (mode 1) that is neither the first tick nor skipped as idle returns one
// item with flow (Q16.16 l/h), the running total in Q16.16 ml, the reported
// pulses, the empty-tank flag, the working scale and the calibration status.
// Such a tick is offered on the output after the volume product, the two flow
// products, the flow division and the total update, plus a scale product and
// division when it closes a calibration window with fuel used: one shared
// 32x32 multiplier runs four products in turn and one restoring divider gives
// one quotient bit per cycle over 80 steps. The block takes a new item only
// while its sequencer is idle; a finished item waits in the output register,
// and a second one holds the sequencer until the first is taken.
// Write configuration only while the block is idle.
module pulse_flow_meter import pfm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  pfm_in_if.sink      item_in,
  pfm_out_if.source   item_out,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // configuration
  logic [15:0] debounce_us;
  logic [23:0] idle_window_us;
  logic [15:0] calib_volume_ml;
  logic [31:0] empty_diff_ml;
  logic [31:0] empty_min_ml;

  // meter state
  logic [TimeW-1:0]  last_edge_time;
  logic              edge_valid;
  logic [CountW-1:0] window_pulses;
  logic [TimeW-1:0]  window_interval_sum;
  logic [TimeW-1:0]  last_read_time;
  logic              read_valid;
  logic [TotalW-1:0] total_ml;
  logic [TotalW-1:0] prev_total_ml;
  logic              cal_running;
  logic [TotalW-1:0] cal_start_ml;
  logic [ScaleW-1:0] work_scale;
  logic              await_first_arm;

  // per-tick working registers
  logic [CountW-1:0] pulses;
  logic [TimeW-1:0]  sum;
  logic              spraying;
  logic              armed;
  logic              calib;
  logic [VolW-1:0]   vol;
  logic [NumW-1:0]   acc;
  logic [31:0]       flow;
  logic [1:0]        status;

  state_t state, state_next;

  logic [MulW-1:0]   mul_a;
  logic [MulW-1:0]   mul_b;
  logic [2*MulW-1:0] prod;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic              in_take;
  logic              out_free;
  logic [TimeW-1:0]  edge_delta;
  logic [TimeW-1:0]  read_elapsed;
  logic              read_skip;
  logic [TimeW:0]    sum_add;
  logic [VolW:0]     total_add;
  logic [TotalW-1:0] total_sat;
  logic [TotalW-1:0] total_diff;
  logic              low_use;
  logic              empty_now;

  assign item_in.ready = (state == S_IDLE);
  assign in_take       = item_in.valid && item_in.ready;
  assign out_free      = !item_out.valid || item_out.ready;

  assign edge_delta   = item_in.time_us - last_edge_time;
  assign read_elapsed = item_in.time_us - last_read_time;
  assign read_skip    = (read_elapsed < {8'b0, idle_window_us}) && (window_pulses == '0);
  assign sum_add      = {1'b0, window_interval_sum} + {1'b0, edge_delta};

  assign total_add = {9'b0, total_ml} + {1'b0, vol};
  assign total_sat = (|total_add[VolW:TotalW]) ? '1 : total_add[TotalW-1:0];
  assign total_diff = total_ml - prev_total_ml;

  // a drop in the total counts as low consumption
  assign low_use   = (total_ml < prev_total_ml) || (total_diff < {16'b0, empty_diff_ml});
  assign empty_now = spraying && armed && low_use && (pulses == '0) &&
                     (total_ml > {16'b0, empty_min_ml});

  // shared multiplier, operands chosen by the sequencer
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MVOL: begin
        mul_a = {8'b0, pulses};
        mul_b = work_scale;
      end
      S_MLO: begin
        mul_a = {4'b0, vol[HalfVol-1:0]};
        mul_b = {10'b0, LphFactor};
      end
      S_MHI: begin
        mul_a = {4'b0, vol[VolW-1:HalfVol]};
        mul_b = {10'b0, LphFactor};
      end
      S_CMUL: begin
        mul_a = {16'b0, calib_volume_ml};
        mul_b = work_scale;
      end
      default: ;
    endcase
  end
  assign prod = mul_a * mul_b;

  always_comb begin
    div_req.start = (state == S_FSTART) || (state == S_CSTART);
    div_req.num   = acc;
    div_req.den   = (state == S_CSTART) ? (total_ml - cal_start_ml) : {16'b0, sum};
  end

  pfm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_take && item_in.mode && read_valid && !read_skip) state_next = S_MVOL;
      end
      S_MVOL:   state_next = S_MLO;
      S_MLO:    state_next = S_MHI;
      S_MHI:    state_next = S_FSTART;
      S_FSTART: state_next = S_FWAIT;
      S_FWAIT:  if (div_rsp.done) state_next = S_TOTAL;
      S_TOTAL: begin
        if (!calib && cal_running && (total_sat > cal_start_ml)) state_next = S_CMUL;
        else state_next = S_FINISH;
      end
      S_CMUL:   state_next = S_CSTART;
      S_CSTART: state_next = S_CWAIT;
      S_CWAIT:  if (div_rsp.done) state_next = S_FINISH;
      S_FINISH: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_us         <= DebounceRst;
      idle_window_us      <= IdleWindowRst;
      calib_volume_ml     <= CalibVolRst;
      empty_diff_ml       <= EmptyDiffRst;
      empty_min_ml        <= EmptyMinRst;
      last_edge_time      <= '0;
      edge_valid          <= 1'b0;
      window_pulses       <= '0;
      window_interval_sum <= '0;
      last_read_time      <= '0;
      read_valid          <= 1'b0;
      total_ml            <= '0;
      prev_total_ml       <= '0;
      cal_running         <= 1'b0;
      cal_start_ml        <= '0;
      work_scale          <= MlPerPulseRst;
      await_first_arm     <= 1'b1;
      item_out.valid      <= 1'b0;
    end else begin
      // in S_FINISH the output register is reloaded below instead
      if (item_out.valid && item_out.ready && (state != S_FINISH)) item_out.valid <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_index)
          RegMlPerPulse: work_scale      <= cfg_data;
          RegDebounce:   debounce_us     <= cfg_data[15:0];
          RegIdleWindow: idle_window_us  <= cfg_data[23:0];
          RegCalibVol:   calib_volume_ml <= cfg_data[15:0];
          RegEmptyDiff:  empty_diff_ml   <= cfg_data;
          RegEmptyMin:   empty_min_ml    <= cfg_data;
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_take && !item_in.mode) begin
            // pulse edge: first one sets the reference, short ones drop
            if (!edge_valid) begin
              edge_valid     <= 1'b1;
              last_edge_time <= item_in.time_us;
            end else if (edge_delta >= {16'b0, debounce_us}) begin
              if (window_pulses != '1) window_pulses <= window_pulses + 1'b1;
              window_interval_sum <= sum_add[TimeW] ? '1 : sum_add[TimeW-1:0];
              last_edge_time      <= item_in.time_us;
            end
          end else if (in_take) begin
            if (!read_valid) begin
              read_valid     <= 1'b1;
              last_read_time <= item_in.time_us;
            end else if (!read_skip) begin
              // close the window and latch the tick
              pulses              <= window_pulses;
              sum                 <= window_interval_sum;
              window_pulses       <= '0;
              window_interval_sum <= '0;
              last_read_time      <= item_in.time_us;
              spraying            <= item_in.spraying;
              armed               <= item_in.armed;
              calib               <= item_in.calib_request;
              status              <= CalNone;
            end
          end
        end
        S_MVOL: vol <= prod[VolW-1:0];
        S_MLO:  acc <= {16'b0, prod};
        S_MHI:  acc <= acc + ({16'b0, prod} << HalfVol);
        S_FWAIT: begin
          if (div_rsp.done) begin
            if (vol == '0)                 flow <= '0;
            else if (sum == '0)            flow <= '1;
            else if (|div_rsp.quo[NumW-1:32]) flow <= '1;
            else                           flow <= div_rsp.quo[31:0];
          end
        end
        S_TOTAL: begin
          total_ml <= total_sat;
          if (calib && !cal_running) begin
            cal_running  <= 1'b1;
            cal_start_ml <= total_sat;
          end else if (!calib && cal_running) begin
            cal_running <= 1'b0;
            if (!(total_sat > cal_start_ml)) status <= CalNoFuel;
          end
        end
        S_CMUL: acc <= {16'b0, prod[47:0], 16'b0};
        S_CWAIT: begin
          if (div_rsp.done) begin
            work_scale <= (|div_rsp.quo[NumW-1:32]) ? '1 : div_rsp.quo[31:0];
            total_ml   <= '0;
            status     <= CalUpdated;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            prev_total_ml <= total_ml;
            if (armed) begin
              if (await_first_arm) begin
                await_first_arm <= 1'b0;
                total_ml        <= '0;
              end
            end else begin
              await_first_arm <= 1'b1;
            end
            item_out.valid           <= 1'b1;
            item_out.flow_lph        <= flow;
            item_out.consumed_ml     <= (armed && await_first_arm) ? '0 : total_ml;
            item_out.pulses_reported <= spraying ? pulses : '0;
            item_out.tank_empty      <= empty_now;
            item_out.scale_now       <= work_scale;
            item_out.calib_status    <= status;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
